[rtl/bzrw_pkg.sv]
package bzrw_pkg;

	localparam logic [47:0] BLOCK_MAGIC = 48'h314159265359;
	localparam logic [47:0] EOS_MAGIC   = 48'h177245385090;
	localparam logic [4:0]  HDR_BYTES   = 5'd10;
	localparam logic [3:0]  LEVEL_RESET = 4'd9;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_scan;
		logic       end_of_file;
	} in_word_t;

	// Everything one input word produces, ready for the byte emitter.
	// Post-header stream: resv top r bits, then end magic + crc (if tail), zero pad.
	typedef struct packed {
		logic        hdr;
		logic        tail;
		logic        eos;
		logic [5:0]  r;
		logic [63:0] resv;
		logic [31:0] crc;
		logic [4:0]  ntot;
	} res_desc_t;

endpackage

[rtl/bzrw_if.sv]
interface bzrw_scan_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_of_scan;
	logic       end_of_file;

	modport source (output valid, output data_byte, output start_of_scan,
		output end_of_file, input ready);
	modport sink (input valid, input data_byte, input start_of_scan,
		input end_of_file, output ready);
endinterface

interface bzrw_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;
	logic       eos_seen;

	modport source (output valid, output out_byte, output last, output eos_seen,
		input ready);
	modport sink (input valid, input out_byte, input last, input eos_seen,
		output ready);
endinterface

[rtl/bzrw_block_rewrapper.sv]
// bzip2 block rewrapper.
// scan: bzip2 file bytes, MSB first. start_of_scan clears the scanner and
//   puts the 10-byte header ("BZh", level digit, block magic) ahead of the
//   bytes of this word; end_of_file flushes and closes an open block, and also ends the stream while still searching.
// rewrap: bytes of the rebuilt single-block stream; last marks the final
//   byte, eos_seen tells whether an end-of-stream magic was seen.
// cfg_we/cfg_wdata: block size level digit, write only while idle.
// Order: a word is registered in the input register at accept; its bytes are
//   built and loaded into the result register once that is free, and rewrap reads them from there.
// Throughput: one word per cycle while rewrap is ready and each word gives at most one byte.
//   A word that gives more bytes holds the input until its last byte is taken,
//   since the result register drains one byte per cycle (header and tail bursts).
// Stall: when rewrap is not ready the result register holds, the input
//   register fills and holds, and scan.ready drops; nothing is lost.
// Reset: scanner cleared, searching for a magic, level set to 9.
module bzip2_block_rewrapper (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,
	bzrw_scan_if.sink   scan,
	bzrw_out_if.source  rewrap
);

	logic [3:0]          lvl_q;
	logic                vld_s1;
	bzrw_pkg::in_word_t  word_s1;
	bzrw_pkg::res_desc_t desc;
	logic                free;
	logic                go;

	assign go         = vld_s1 && free;
	assign scan.ready = !vld_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q <= bzrw_pkg::LEVEL_RESET;
		end else if (cfg_we) begin
			lvl_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (scan.valid && scan.ready) begin
			vld_s1 <= 1'b1;
		end else if (go) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (scan.valid && scan.ready) begin
			word_s1.data_byte     <= scan.data_byte;
			word_s1.start_of_scan <= scan.start_of_scan;
			word_s1.end_of_file   <= scan.end_of_file;
		end
	end

	bzrw_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.word   (word_s1),
		.desc   (desc)
	);

	bzrw_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.desc   (desc),
		.level  (lvl_q),
		.free   (free),
		.rewrap (rewrap)
	);

endmodule

[rtl/bzrw_scan.sv]
module bzrw_scan (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  bzrw_pkg::in_word_t   word,
	output bzrw_pkg::res_desc_t  desc
);

	typedef enum logic [1:0] {PH_SEARCH, PH_OPEN, PH_DONE} phase_t;

	logic [47:0] win_q;
	phase_t      phase_q;
	logic [5:0]  cnt_q;
	logic [31:0] crc_q;
	logic [7:0]  pack_q;   // left aligned, pcnt_q bits valid
	logic [2:0]  pcnt_q;
	logic        eos_q;

	logic [47:0] win_n;
	phase_t      phase_n;
	logic [5:0]  cnt_n;
	logic [31:0] crc_n;
	logic [7:0]  pack_n;
	logic [2:0]  pcnt_n;
	logic        eos_n;

	always_comb begin
		logic [47:0] e_win;
		phase_t      e_ph;
		logic [5:0]  e_cnt;
		logic [31:0] e_crc;
		logic [7:0]  e_pack;
		logic [2:0]  e_pcnt;
		logic        e_eos;
		logic [55:0] comb;
		logic        active;
		phase_t      ph;
		logic [5:0]  ct;
		logic [31:0] crc;
		logic        eos;
		logic        closed;
		logic [3:0]  nl;
		logic [2:0]  t0;
		logic [47:0] wnd;
		logic        flush;
		logic        tail;
		logic [6:0]  d;
		logic [5:0]  sh;
		logic [55:0] slice;
		logic [63:0] resv;
		logic [5:0]  r;
		logic [4:0]  nb;
		logic [63:0] tmp;

		e_win  = word.start_of_scan ? 48'd0 : win_q;
		e_ph   = word.start_of_scan ? PH_SEARCH : phase_q;
		e_cnt  = word.start_of_scan ? 6'd0 : cnt_q;
		e_crc  = word.start_of_scan ? 32'd0 : crc_q;
		e_pack = word.start_of_scan ? 8'd0 : pack_q;
		e_pcnt = word.start_of_scan ? 3'd0 : pcnt_q;
		e_eos  = word.start_of_scan ? 1'b0 : eos_q;

		comb   = {e_win, word.data_byte};
		active = (e_ph == PH_SEARCH) || (e_ph == PH_OPEN);
		ph     = e_ph;
		ct     = e_cnt;
		crc    = e_crc;
		eos    = e_eos;
		closed = 1'b0;
		nl     = 4'd0;
		t0     = 3'd0;
		wnd    = 48'd0;

		// window after bit t is comb[54-t -: 48]; the compares are independent
		for (int t = 0; t < 8; t++) begin
			if (active && !closed) begin
				if (ph == PH_OPEN && ct >= 6'd48) begin
					if (nl == 4'd0)
						t0 = 3'(t);
					nl = nl + 4'd1;
				end
				if (ph == PH_OPEN && ct < 6'd48)
					ct = ct + 6'd1;
				wnd = comb[54-t -: 48];
				if (wnd == bzrw_pkg::BLOCK_MAGIC || wnd == bzrw_pkg::EOS_MAGIC) begin
					if (wnd == bzrw_pkg::EOS_MAGIC)
						eos = 1'b1;
					if (ph == PH_SEARCH) begin
						ph = PH_OPEN;
						ct = 6'd0;
					end else begin
						closed = 1'b1;
					end
				end
				if (!closed && ph == PH_OPEN && ct == 6'd32)
					crc = comb[38-t -: 32];
			end
		end

		flush = active && !closed && word.end_of_file && (ph == PH_OPEN);
		tail  = active && (closed || word.end_of_file);

		// emitted data bits are one run of comb, starting at t0 or at the flush
		d  = {3'b000, nl} + (flush ? {1'b0, ct} : 7'd0);
		sh = (nl != 4'd0) ? {3'b000, t0} : 6'(7'd56 - {1'b0, ct});
		slice = (comb << sh) & ~({56{1'b1}} >> d);
		resv  = {e_pack, 56'd0} | ({slice, 8'd0} >> e_pcnt);
		r     = {3'b000, e_pcnt} + 6'(d);
		nb    = tail ? 5'(({2'b00, r} + 8'd87) >> 3) : {2'b00, r[5:3]};
		tmp   = resv << {r[5:3], 3'b000};

		desc.hdr  = word.start_of_scan;
		desc.tail = tail;
		desc.eos  = eos;
		desc.r    = r;
		desc.resv = resv;
		desc.crc  = crc;
		desc.ntot = (word.start_of_scan ? bzrw_pkg::HDR_BYTES : 5'd0) + nb;

		if (active) begin
			win_n   = comb[47:0];
			phase_n = tail ? PH_DONE : ph;
			cnt_n   = ct;
			crc_n   = crc;
			eos_n   = eos;
			pack_n  = tail ? 8'd0 : tmp[63:56];
			pcnt_n  = tail ? 3'd0 : r[2:0];
		end else begin
			win_n   = e_win;
			phase_n = e_ph;
			cnt_n   = e_cnt;
			crc_n   = e_crc;
			eos_n   = e_eos;
			pack_n  = e_pack;
			pcnt_n  = e_pcnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= '0;
			phase_q <= PH_SEARCH;
			cnt_q   <= '0;
			crc_q   <= '0;
			pack_q  <= '0;
			pcnt_q  <= '0;
			eos_q   <= 1'b0;
		end else if (go) begin
			win_q   <= win_n;
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			crc_q   <= crc_n;
			pack_q  <= pack_n;
			pcnt_q  <= pcnt_n;
			eos_q   <= eos_n;
		end
	end

endmodule

[rtl/bzrw_emit.sv]
module bzrw_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  bzrw_pkg::res_desc_t desc,
	input  logic [3:0]          level,
	output logic                free,
	bzrw_out_if.source          rewrap
);

	bzrw_pkg::res_desc_t res_q;
	logic                vld_q;
	logic [4:0]          k_q;

	logic       at_last;
	logic       take;
	logic [7:0] byte_n;

	function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input logic [3:0] lvl);
		logic [7:0] v;
		unique case (idx)
			4'd0:    v = 8'h42;
			4'd1:    v = 8'h5A;
			4'd2:    v = 8'h68;
			4'd3:    v = 8'h30 + {4'h0, lvl};
			4'd4:    v = 8'h31;
			4'd5:    v = 8'h41;
			4'd6:    v = 8'h59;
			4'd7:    v = 8'h26;
			4'd8:    v = 8'h53;
			4'd9:    v = 8'h59;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	always_comb begin
		logic [4:0]  kp;
		logic [7:0]  j;
		logic [7:0]  q;
		logic [79:0] tl;

		tl = {bzrw_pkg::EOS_MAGIC, res_q.crc};
		kp = k_q - (res_q.hdr ? bzrw_pkg::HDR_BYTES : 5'd0);
		j  = 8'd0;
		q  = 8'd0;
		byte_n = 8'd0;
		if (res_q.hdr && k_q < bzrw_pkg::HDR_BYTES) begin
			byte_n = hdr_byte(k_q[3:0], level);
		end else begin
			for (int b = 0; b < 8; b++) begin
				j = {kp, 3'b000} + 8'(b);
				q = j - {2'b00, res_q.r};
				if (j < {2'b00, res_q.r})
					byte_n[7-b] = res_q.resv[~j[5:0]];
				else if (res_q.tail && q < 8'd80)
					byte_n[7-b] = tl[7'(8'd79 - q)];
				else
					byte_n[7-b] = 1'b0;
			end
		end
	end

	assign at_last = (k_q == res_q.ntot - 5'd1);
	assign take    = rewrap.valid && rewrap.ready;
	assign free    = !vld_q || (take && at_last);

	assign rewrap.valid    = vld_q;
	assign rewrap.out_byte = byte_n;
	assign rewrap.last     = res_q.tail && at_last;
	assign rewrap.eos_seen = res_q.eos;

	// a load only happens when the current word is gone or leaves now
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			k_q   <= '0;
		end else if (go && desc.ntot != 5'd0) begin
			vld_q <= 1'b1;
			k_q   <= '0;
		end else if (take) begin
			if (at_last)
				vld_q <= 1'b0;
			else
				k_q <= k_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (go && desc.ntot != 5'd0)
			res_q <= desc;
	end

endmodule

[sim/bzrw_stream_checker.sv]
module bzrw_stream_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata,
	bzrw_scan_if       scan,
	bzrw_out_if        rewrap,
	output int         mismatches,
	output int         bytes_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {
		SCAN_HUNT  = 2'd0,
		SCAN_BLOCK = 2'd1,
		SCAN_DONE  = 2'd2
	} scan_stage_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
		logic       eos_seen;
	} rebuilt_byte_t;

	rebuilt_byte_t owed_q[$];
	logic [7:0]    step_bytes[$];
	bit            step_closed;

	logic [3:0]    level;
	logic [47:0]   window;
	scan_stage_t   stage;
	int            blk_bits;
	logic [31:0]   crc_word;
	logic [7:0]    acc;
	int            acc_fill;
	logic          eos_hit;

	function automatic void clear_scanner();
		window   = '0;
		stage    = SCAN_HUNT;
		blk_bits = 0;
		crc_word = '0;
		acc      = '0;
		acc_fill = 0;
		eos_hit  = 1'b0;
	endfunction

	function automatic void pack_bit(logic b);
		acc = {acc[6:0], b};
		acc_fill++;
		if (acc_fill == 8) begin
			step_bytes.push_back(acc);
			acc      = '0;
			acc_fill = 0;
		end
	endfunction

	function automatic void pack_byte(logic [7:0] v);
		for (int i = 7; i >= 0; i--)
			pack_bit(v[i]);
	endfunction

	// end magic, crc, zero pad to the byte boundary
	function automatic void close_block();
		for (int i = 5; i >= 0; i--)
			pack_byte(bzrw_pkg::EOS_MAGIC[i * 8 +: 8]);
		for (int i = 31; i >= 0; i--)
			pack_bit(crc_word[i]);
		while (acc_fill != 0)
			pack_bit(1'b0);
		step_closed = 1'b1;
		stage       = SCAN_DONE;
	endfunction

	function automatic void rebuild_word(logic [7:0] b, logic sos, logic eof);
		step_bytes.delete();
		step_closed = 1'b0;
		if (sos) begin
			clear_scanner();
			pack_byte("B");
			pack_byte("Z");
			pack_byte("h");
			pack_byte(8'h30 + {4'b0000, level});
			for (int i = 5; i >= 0; i--)
				pack_byte(bzrw_pkg::BLOCK_MAGIC[i * 8 +: 8]);
		end
		if (stage == SCAN_HUNT || stage == SCAN_BLOCK) begin
			for (int i = 7; i >= 0; i--) begin
				// data leaves the window 48 bits late so a closing magic never goes out
				if (stage == SCAN_BLOCK && blk_bits >= 48)
					pack_bit(window[47]);
				window = {window[46:0], b[i]};
				if (stage == SCAN_BLOCK && blk_bits < 48)
					blk_bits++;
				if (window == bzrw_pkg::BLOCK_MAGIC || window == bzrw_pkg::EOS_MAGIC) begin
					if (window == bzrw_pkg::EOS_MAGIC)
						eos_hit = 1'b1;
					if (stage == SCAN_HUNT) begin
						stage    = SCAN_BLOCK;
						blk_bits = 0;
					end else begin
						close_block();
						break;
					end
				end
				if (stage == SCAN_BLOCK && blk_bits == 32)
					crc_word = window[31:0];
			end
			if (eof && stage != SCAN_DONE) begin
				if (stage == SCAN_BLOCK)
					for (int k = blk_bits - 1; k >= 0; k--)
						pack_bit(window[k]);
				close_block();
			end
		end
		foreach (step_bytes[k])
			owed_q.push_back('{step_bytes[k], step_closed && (k == step_bytes.size() - 1),
				eos_hit});
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rebuilt_byte_t want;
		if (!arst_n) begin
			level = bzrw_pkg::LEVEL_RESET;
			clear_scanner();
			owed_q.delete();
			bytes_owed = 0;
		end else begin
			if (cfg_we)
				level = cfg_wdata;
			if (scan.valid && scan.ready)
				rebuild_word(scan.data_byte, scan.start_of_scan, scan.end_of_file);
			if (rewrap.valid && rewrap.ready) begin
				if (owed_q.size() == 0) begin
					$error("unexpected word: out_byte %h last %b eos_seen %b",
						rewrap.out_byte, rewrap.last, rewrap.eos_seen);
					mismatches++;
				end else begin
					want = owed_q.pop_front();
					if (rewrap.out_byte !== want.out_byte) begin
						$error("out_byte: expected %h, got %h", want.out_byte, rewrap.out_byte);
						mismatches++;
					end
					if (rewrap.last !== want.last) begin
						$error("last: expected %b, got %b", want.last, rewrap.last);
						mismatches++;
					end
					if (rewrap.eos_seen !== want.eos_seen) begin
						$error("eos_seen: expected %b, got %b", want.eos_seen, rewrap.eos_seen);
						mismatches++;
					end
				end
			end
			bytes_owed = owed_q.size();
		end
	end

endmodule

[sim/tb_bzip2_block_rewrapper.sv]
module tb_bzip2_block_rewrapper;
	timeunit 1ns;
	timeprecision 1ps;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [3:0] cfg_wdata;
	int         mismatches;
	int         bytes_owed;
	int         src_gap_max;
	int         snk_gap_max;
	int         words_sent;
	bit         file_bits[$];
	logic [3:0] level_plan[4] = '{4'd1, 4'd15, 4'd0, 4'd9};

	bzrw_scan_if scan_ch();
	bzrw_out_if  rewrap_ch();

	bzip2_block_rewrapper dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.scan     (scan_ch),
		.rewrap   (rewrap_ch)
	);

	bzrw_stream_checker stream_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.scan      (scan_ch),
		.rewrap    (rewrap_ch),
		.mismatches(mismatches),
		.bytes_owed(bytes_owed)
	);

	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("bzip2_block_rewrapper test failed");
		$finish;
	end

	// sink side: random stall before each word
	initial begin
		int stall;
		rewrap_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = $urandom_range(0, snk_gap_max);
			if (stall > 0) begin
				rewrap_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rewrap_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rewrap_ch.valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	// starts and ends on a falling edge; valid stays up when the next word has no gap
	task automatic send_word(input logic [7:0] b, input logic sos, input logic eof);
		int gap;
		gap = $urandom_range(0, src_gap_max);
		if (gap > 0) begin
			scan_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		scan_ch.valid         <= 1'b1;
		scan_ch.data_byte     <= b;
		scan_ch.start_of_scan <= sos;
		scan_ch.end_of_file   <= eof;
		@(posedge clk);
		while (!scan_ch.ready)
			@(posedge clk);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic write_level(input logic [3:0] v);
		scan_ch.valid <= 1'b0;
		while (bytes_owed != 0)
			@(negedge clk);
		repeat (24) @(negedge clk);
		cfg_wdata <= v;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic void add_bits(logic [47:0] v, int n);
		for (int i = n - 1; i >= 0; i--)
			file_bits.push_back(v[i]);
	endfunction

	function automatic void add_noise(int n);
		for (int i = 0; i < n; i++)
			file_bits.push_back(1'($urandom_range(0, 1)));
	endfunction

	// one bit stream: optional prefix, opening magic, crc + body, closing magic or eof; or 1 to 12 random words
	task automatic send_file();
		int         shape;
		int         closing;
		int         nbytes;
		bit         with_sos;
		logic [7:0] b;
		logic       eof;
		file_bits.delete();
		shape    = $urandom_range(0, 15);
		with_sos = ($urandom_range(0, 9) != 0);
		if (shape == 0) begin
			repeat ($urandom_range(1, 12))
				send_word(8'($urandom), 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
			return;
		end
		if (shape < 6)
			add_bits(48'h0000_425A_6839, 32);  // BZh9 file header, magic lands aligned
		else
			add_noise($urandom_range(0, 23));
		add_bits(($urandom_range(0, 3) == 0) ? bzrw_pkg::EOS_MAGIC : bzrw_pkg::BLOCK_MAGIC, 48);
		add_noise(($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(41, 110));
		closing = $urandom_range(0, 3);
		if (closing < 2)
			add_bits(bzrw_pkg::BLOCK_MAGIC, 48);
		else if (closing == 2)
			add_bits(bzrw_pkg::EOS_MAGIC, 48);
		add_noise($urandom_range(0, 16));
		while (file_bits.size() % 8 != 0)
			file_bits.push_back(1'($urandom_range(0, 1)));
		nbytes = file_bits.size() / 8;
		for (int i = 0; i < nbytes; i++) begin
			for (int j = 0; j < 8; j++)
				b = {b[6:0], file_bits[8 * i + j]};
			eof = (i == nbytes - 1) && (closing == 3 || $urandom_range(0, 1) == 1);
			send_word(b, with_sos && i == 0, eof);
		end
	endtask

	initial begin
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_wdata             = '0;
		scan_ch.valid         = 1'b0;
		scan_ch.data_byte     = '0;
		scan_ch.start_of_scan = 1'b0;
		scan_ch.end_of_file   = 1'b0;
		src_gap_max           = 10;
		snk_gap_max           = 10;
		words_sent            = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// no start yet: scanned but no header
		send_word(8'hFF, 1'b0, 1'b0);
		// block magic opens, end magic right after closes with no data bits
		send_word(bzrw_pkg::BLOCK_MAGIC[47:40], 1'b1, 1'b0);
		for (int i = 4; i >= 0; i--)
			send_word(bzrw_pkg::BLOCK_MAGIC[i * 8 +: 8], 1'b0, 1'b0);
		for (int i = 5; i >= 0; i--)
			send_word(bzrw_pkg::EOS_MAGIC[i * 8 +: 8], 1'b0, 1'b0);
		// done: ignored until the next start
		send_word(8'hA5, 1'b0, 1'b0);
		// end of file while still searching: header and tail in one word
		send_word(8'h00, 1'b1, 1'b1);
		// short block flushed by end of file, crc stays zero
		send_word(bzrw_pkg::BLOCK_MAGIC[47:40], 1'b1, 1'b0);
		for (int i = 4; i >= 0; i--)
			send_word(bzrw_pkg::BLOCK_MAGIC[i * 8 +: 8], 1'b0, 1'b0);
		send_word(8'h80, 1'b0, 1'b1);
		send_word(8'h5A, 1'b0, 1'b1);

		for (int f = 0; words_sent < 250; f++) begin
			if (f % 4 == 0)
				write_level(f < 16 ? level_plan[f / 4] : 4'($urandom_range(0, 15)));
			src_gap_max = ($urandom_range(0, 4) == 0) ? 0 : 10;
			snk_gap_max = ($urandom_range(0, 4) == 0) ? 0 : 10;
			send_file();
		end

		scan_ch.valid <= 1'b0;
		while (bytes_owed != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		if (mismatches == 0)
			$display("bzip2_block_rewrapper test passed");
		else
			$display("bzip2_block_rewrapper test failed");
		$finish;
	end

endmodule

[bzip2_block_rewrapper.f]
rtl/bzrw_pkg.sv
rtl/bzrw_if.sv
rtl/bzrw_scan.sv
rtl/bzrw_emit.sv
rtl/bzrw_block_rewrapper.sv
sim/bzrw_stream_checker.sv
sim/tb_bzip2_block_rewrapper.sv
